// ===== src/prdg_pkg.sv =====
// Shared types and constants for the pinhole ray direction generator.
`default_nettype none
package prdg_pkg;
  localparam int unsigned DefMaxWidth  = 4096;
  localparam int unsigned DefMaxHeight = 4096;

  typedef enum logic [2:0] {
    RegWidth  = 3'd0,
    RegHeight = 3'd1,
    RegLeft   = 3'd2,
    RegTop    = 3'd3,
    RegStepX  = 3'd4,
    RegStepY  = 3'd5,
    RegZoom   = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StZero  = 2'd1,
    StRange = 2'd2
  } status_e;

  // Per-item data that rides alongside the sqrt and divide stages.
  typedef struct packed {
    logic signed [24:0] rx;
    logic signed [24:0] ry;
    logic signed [24:0] rz;
    logic [4:0]         half;
    logic [23:0]        idx;
    status_e            st;
  } side_t;
endpackage
`default_nettype wire

// ===== src/pinhole_ray_direction_gen.sv =====
// Pinhole camera primary ray generator: pixel (x, y) to unit direction in Q1.15.
//
// Fully pipelined: one pixel accepted, one ray out per clock unless the output
// stalls. Stages: edge/step multiply, saturate and index, three squarers, sum,
// leading-one search, normalize, 16 stages of an integer square root (two digits
// per stage, one in the last), operand shift, 8 stages of three two-bit-per-stage
// restoring dividers, and the output register. An output stall holds the whole pipeline.
`default_nettype none
module pinhole_ray_direction_gen #(
  parameter int unsigned MAX_WIDTH  = prdg_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = prdg_pkg::DefMaxHeight
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [23:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // pixel_x[11:0], pixel_y[23:12]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata    // dir_x, dir_y, dir_z, pixel_index, status, pad
);

  localparam int unsigned SqStages = 16;
  localparam int unsigned DvStages = 8;

  typedef struct packed {
    logic              v;
    prdg_pkg::side_t   sd;
    logic [61:0]       t;
    logic [33:0]       rem;
    logic [30:0]       root;
  } sq_t;

  typedef struct packed {
    logic              v;
    prdg_pkg::side_t   sd;
    logic [2:0][31:0]  rem;
    logic [2:0][15:0]  q;
    logic [30:0]       root;
  } dv_t;

  // configuration
  logic [12:0]        width_q, height_q;
  logic signed [23:0] left_q, top_q, stepx_q, stepy_q, zoom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd1000;
      height_q <= 13'd1000;
      left_q   <= -24'sd65536;
      top_q    <= -24'sd65536;
      stepx_q  <= 24'sd131;
      stepy_q  <= 24'sd131;
      zoom_q   <= 24'sd65536;
    end else if (cfg_we_i) begin
      case (prdg_pkg::cfg_reg_e'(cfg_addr_i))
        prdg_pkg::RegWidth:  width_q  <= cfg_wdata_i[12:0];
        prdg_pkg::RegHeight: height_q <= cfg_wdata_i[12:0];
        prdg_pkg::RegLeft:   left_q   <= cfg_wdata_i;
        prdg_pkg::RegTop:    top_q    <= cfg_wdata_i;
        prdg_pkg::RegStepX:  stepx_q  <= cfg_wdata_i;
        prdg_pkg::RegStepY:  stepy_q  <= cfg_wdata_i;
        prdg_pkg::RegZoom:   zoom_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  function automatic logic signed [24:0] sat25(input logic signed [38:0] v);
    logic signed [24:0] r;
    if (v > 39'sd16777215)       r = 25'sd16777215;
    else if (v < -39'sd16777216) r = -25'sd16777216;
    else                         r = v[24:0];
    return r;
  endfunction

  function automatic sq_t sq_step(input sq_t a);
    sq_t        r;
    logic [33:0] rem2, trial;
    r     = a;
    rem2  = {a.rem[31:0], a.t[61:60]};
    trial = {1'b0, a.root, 2'b01};
    r.t   = {a.t[59:0], 2'b00};
    if (rem2 >= trial) begin
      r.rem  = rem2 - trial;
      r.root = {a.root[29:0], 1'b1};
    end else begin
      r.rem  = rem2;
      r.root = {a.root[29:0], 1'b0};
    end
    return r;
  endfunction

  function automatic dv_t dv_step(input dv_t a);
    dv_t r;
    r = a;
    for (int c = 0; c < 3; c++) begin
      if (a.rem[c] >= {1'b0, a.root}) begin
        r.q[c]   = {a.q[c][14:0], 1'b1};
        r.rem[c] = (a.rem[c] - {1'b0, a.root}) << 1;
      end else begin
        r.q[c]   = {a.q[c][14:0], 1'b0};
        r.rem[c] = a.rem[c] << 1;
      end
    end
    return r;
  endfunction

  // stage 1: multiplies
  logic [11:0] px, py;
  logic [12:0] w_eff, h_eff;
  assign px    = s_axis_tdata[11:0];
  assign py    = s_axis_tdata[23:12];
  assign w_eff = (32'(width_q) > 32'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : width_q;
  assign h_eff = (32'(height_q) > 32'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : height_q;

  logic               s1_v_q, s1_oor_q;
  logic [11:0]        s1_px_q;
  logic signed [37:0] s1_px_prod_q, s1_py_prod_q;
  logic [24:0]        s1_iprod_q;

  // stage 2
  logic            s2_v_q;
  prdg_pkg::side_t s2_q;
  // stage 3
  logic            s3_v_q;
  prdg_pkg::side_t s3_q;
  logic [48:0]     s3_sqx_q, s3_sqy_q, s3_sqz_q;
  // stage 4
  logic            s4_v_q;
  prdg_pkg::side_t s4_q;
  logic [50:0]     s4_sum_q;
  // stage 5
  logic            s5_v_q;
  prdg_pkg::side_t s5_d, s5_q;
  logic [50:0]     s5_sum_q;

  logic signed [38:0] rx_sum, ry_sum;
  assign rx_sum = 39'($signed({left_q, 1'b0})) + 39'(s1_px_prod_q);
  assign ry_sum = 39'($signed({top_q, 1'b0})) + 39'(s1_py_prod_q);

  logic signed [49:0] sqx, sqy, sqz;
  assign sqx = s2_q.rx * s2_q.rx;
  assign sqy = s2_q.ry * s2_q.ry;
  assign sqz = s2_q.rz * s2_q.rz;

  logic [5:0] msb;
  always_comb begin
    msb = '0;
    for (int i = 0; i < 51; i++) begin
      if (s4_sum_q[i]) msb = 6'(i);
    end
  end

  always_comb begin
    s5_d      = s4_q;
    s5_d.half = (s4_sum_q == '0) ? 5'd0 : 5'((7'd61 - 7'(msb)) >> 1);
    if (s4_sum_q == '0 && s4_q.st == prdg_pkg::StOk) s5_d.st = prdg_pkg::StZero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= s_axis_tvalid;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_oor_q     <= ({1'b0, px} >= w_eff) || ({1'b0, py} >= h_eff);
      s1_px_q      <= px;
      s1_px_prod_q <= stepx_q * $signed({1'b0, px, 1'b1});
      s1_py_prod_q <= stepy_q * $signed({1'b0, py, 1'b1});
      s1_iprod_q   <= py * w_eff;

      s2_q.rx   <= sat25(rx_sum);
      s2_q.ry   <= sat25(ry_sum);
      s2_q.rz   <= {zoom_q, 1'b0};
      s2_q.half <= '0;
      s2_q.idx  <= s1_oor_q ? '0 : 24'(s1_iprod_q + 25'(s1_px_q));
      s2_q.st   <= s1_oor_q ? prdg_pkg::StRange : prdg_pkg::StOk;

      s3_q     <= s2_q;
      s3_sqx_q <= sqx[48:0];
      s3_sqy_q <= sqy[48:0];
      s3_sqz_q <= sqz[48:0];

      s4_q     <= s3_q;
      s4_sum_q <= 51'(s3_sqx_q) + 51'(s3_sqy_q) + 51'(s3_sqz_q);

      s5_q     <= s5_d;
      s5_sum_q <= s4_sum_q;
    end
  end

  // square root pipeline
  sq_t sq_q [SqStages+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q[0] <= '0;
    end else if (en) begin
      sq_q[0].v    <= s5_v_q;
      sq_q[0].sd   <= s5_q;
      sq_q[0].t    <= 62'(s5_sum_q) << {s5_q.half, 1'b0};
      sq_q[0].rem  <= '0;
      sq_q[0].root <= '0;
    end
  end

  for (genvar k = 0; k < SqStages; k++) begin : g_sq
    sq_t one, two;
    assign one = sq_step(sq_q[k]);
    if (2 * k + 1 < 31) begin : g_two
      assign two = sq_step(one);
    end else begin : g_one
      assign two = one;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_q[k+1] <= '0;
      end else if (en) begin
        sq_q[k+1] <= two;
      end
    end
  end

  // divide pipeline
  dv_t dv_q [DvStages+1];
  logic [2:0][24:0] mag;
  always_comb begin
    mag[0] = sq_q[SqStages].sd.rx[24] ? 25'(-sq_q[SqStages].sd.rx) : sq_q[SqStages].sd.rx;
    mag[1] = sq_q[SqStages].sd.ry[24] ? 25'(-sq_q[SqStages].sd.ry) : sq_q[SqStages].sd.ry;
    mag[2] = sq_q[SqStages].sd.rz[24] ? 25'(-sq_q[SqStages].sd.rz) : sq_q[SqStages].sd.rz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= '0;
    end else if (en) begin
      dv_q[0].v    <= sq_q[SqStages].v;
      dv_q[0].sd   <= sq_q[SqStages].sd;
      dv_q[0].root <= sq_q[SqStages].root;
      dv_q[0].q    <= '0;
      for (int c = 0; c < 3; c++) begin
        dv_q[0].rem[c] <= 32'(56'(mag[c]) << sq_q[SqStages].sd.half);
      end
    end
  end

  for (genvar k = 0; k < DvStages; k++) begin : g_dv
    dv_t two;
    assign two = dv_step(dv_step(dv_q[k]));
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= '0;
      end else if (en) begin
        dv_q[k+1] <= two;
      end
    end
  end

  // output register
  dv_t              fin;
  logic [2:0]       neg;
  logic [2:0][15:0] dir_d;
  logic [2:0][15:0] dir_q;
  logic [23:0]      idx_q;
  logic [1:0]       st_q;
  assign fin = dv_q[DvStages];
  assign neg = {fin.sd.rz[24], fin.sd.ry[24], fin.sd.rx[24]};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (fin.sd.st != prdg_pkg::StOk) dir_d[c] = '0;
      else if (neg[c])                 dir_d[c] = 16'(-fin.q[c]);
      else if (fin.q[c][15])           dir_d[c] = 16'h7FFF;
      else                             dir_d[c] = fin.q[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= fin.v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dir_q <= dir_d;
      idx_q <= fin.sd.idx;
      st_q  <= fin.sd.st;
    end
  end

  assign m_axis_tdata = {6'd0, st_q, idx_q, dir_q[2], dir_q[1], dir_q[0]};

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st_q == prdg_pkg::StRange |-> dir_q == '0 && idx_q == '0)
    else $error("out-of-range ray carries data");
  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st_q == prdg_pkg::StZero |-> dir_q == '0)
    else $error("zero-length ray carries a direction");
  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st_q == prdg_pkg::StOk |-> dir_q != '0)
    else $error("valid ray has null direction");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled ray changed");

endmodule
`default_nettype wire
